// ===== sv/v3c_sample_stream_deframer_core_defines.svh =====
// Assertion macros for the sample stream deframer.
`ifndef V3C_SAMPLE_STREAM_DEFRAMER_CORE_DEFINES_SVH
`define V3C_SAMPLE_STREAM_DEFRAMER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define V3CSSD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define V3CSSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define V3CSSD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define V3CSSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/v3cssd_pkg.sv =====
package v3cssd_pkg;

  localparam int unsigned SizeBitsDefault = 32;
  localparam int unsigned OutSizeW        = 32;
  localparam int unsigned UnitHdrBytes    = 4;
  localparam int unsigned SizeLenW        = 4;
  localparam int unsigned SizeLenShift    = 5;
  localparam int unsigned TypeShift       = 3;
  localparam int unsigned TypeW           = 5;

  localparam logic [TypeW-1:0] TypeParamSet = 5'd0;
  localparam logic [TypeW-1:0] TypeAtlas    = 5'd1;
  localparam logic [TypeW-1:0] TypeVideoLo  = 5'd2;
  localparam logic [TypeW-1:0] TypeVideoHi  = 5'd4;

  typedef enum logic [1:0] {
    PhHeader,
    PhSize,
    PhUnitHdr,
    PhPayload
  } phase_e;

  typedef enum logic [1:0] {
    ClassParamSet,
    ClassAtlas,
    ClassVideo,
    ClassUnknown
  } unit_class_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stream_start;
  } in_req_t;

  typedef struct packed {
    logic [TypeW-1:0]    unit_type;
    logic [1:0]          unit_class;
    logic [OutSizeW-1:0] unit_size;
    logic [OutSizeW-1:0] payload_size;
    logic                size_error;
    logic                size_overflow;
  } out_req_t;

  function automatic unit_class_e class_of(logic [TypeW-1:0] t);
    unit_class_e c;
    case (t) inside
      TypeParamSet:              c = ClassParamSet;
      TypeAtlas:                 c = ClassAtlas;
      [TypeVideoLo:TypeVideoHi]: c = ClassVideo;
      default:                   c = ClassUnknown;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/v3c_sample_stream_deframer_core.sv =====
// Channel  Valid        Stall        Request
// input    in_valid_i   in_stall_o   in_req_i  (byte_in, stream_start)
// output   out_valid_o  out_stall_i  out_req_o (unit type, class, sizes, flags)
//
// Input and result are each registered; one byte per cycle while in_stall_o is low.
// The input register feeds the parser, whose result logic is combinational.
// Reset clears the parser to wait for a stream header byte; no result is pending.
// A stalled result holds the parser; with the input register full, in_stall_o rises.
module v3c_sample_stream_deframer_core #(
  parameter int unsigned SIZE_BITS = v3cssd_pkg::SizeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  v3cssd_pkg::in_req_t  in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output v3cssd_pkg::out_req_t out_req_o
);
  import v3cssd_pkg::*;

  logic     fire;
  logic     free;
  logic     res_valid;
  in_req_t  item;
  out_req_t res;

  v3cssd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .req_i   (in_req_i),
    .free_i  (free),
    .fire_o  (fire),
    .req_o   (item)
  );

  v3cssd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  v3cssd_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .res_i   (res),
    .free_o  (free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .req_o   (out_req_o)
  );

endmodule

// ===== sv/v3cssd_in_stage.sv =====
module v3cssd_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  v3cssd_pkg::in_req_t  req_i,
  input  logic                 free_i,
  output logic                 fire_o,
  output v3cssd_pkg::in_req_t  req_o
);
  import v3cssd_pkg::*;

  logic    valid_q, valid_d;
  logic    accept;
  in_req_t req_q;

  assign stall_o = valid_q & ~free_i;
  assign fire_o  = valid_q & free_i;
  assign accept  = valid_i & ~stall_o;
  assign req_o   = req_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

endmodule

// ===== sv/v3cssd_parser.sv =====
`include "v3c_sample_stream_deframer_core_defines.svh"

module v3cssd_parser #(
  parameter int unsigned SIZE_BITS = v3cssd_pkg::SizeBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  v3cssd_pkg::in_req_t  req_i,
  output logic                 res_valid_o,
  output v3cssd_pkg::out_req_t res_o
);
  import v3cssd_pkg::*;

  localparam int unsigned AccW = (SIZE_BITS >= OutSizeW) ? OutSizeW : SIZE_BITS;

  phase_e              phase_q, phase_d;
  logic [SizeLenW-1:0] size_len_q, size_len_d;
  logic [AccW-1:0]     cnt_q, cnt_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [TypeW-1:0]    type_q, type_d;
  logic                ovf_q, ovf_d;

  logic [AccW-1:0]     cnt_inc;
  logic [AccW-1:0]     cnt_dec;
  logic [AccW-1:0]     acc_base;
  logic                ovf_base;
  logic                err;
  logic [AccW-1:0]     pay;

  assign cnt_inc  = cnt_q + 1'b1;
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
  assign acc_base = (cnt_q == '0) ? '0 : acc_q;
  assign ovf_base = (cnt_q == '0) ? 1'b0 : ovf_q;
  assign err      = acc_q < AccW'(UnitHdrBytes);
  assign pay      = err ? '0 : acc_q - AccW'(UnitHdrBytes);

  always_comb begin
    phase_d     = phase_q;
    size_len_d  = size_len_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    type_d      = type_q;
    ovf_d       = ovf_q;
    res_valid_o = 1'b0;

    res_o.unit_type     = type_q;
    res_o.unit_class    = class_of(type_q);
    res_o.unit_size     = OutSizeW'(acc_q);
    res_o.payload_size  = OutSizeW'(pay);
    res_o.size_error    = err;
    res_o.size_overflow = ovf_q;

    if (fire_i) begin
      if (req_i.stream_start) begin
        size_len_d = SizeLenW'(req_i.byte_in >> SizeLenShift) + 1'b1;
        phase_d    = PhSize;
        cnt_d      = '0;
        acc_d      = '0;
        ovf_d      = 1'b0;
      end else begin
        unique case (phase_q)
          PhHeader: begin
          end
          PhSize: begin
            if (ovf_base || (acc_base[AccW-1 -: 8] != '0)) begin
              ovf_d = 1'b1;
              acc_d = '1;
            end else begin
              ovf_d = 1'b0;
              acc_d = {acc_base[AccW-9:0], req_i.byte_in};
            end
            if (cnt_inc >= AccW'(size_len_q)) begin
              phase_d = PhUnitHdr;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          PhUnitHdr: begin
            if (cnt_q == '0) begin
              type_d = req_i.byte_in[7:TypeShift];
            end
            if (cnt_inc < AccW'(UnitHdrBytes)) begin
              cnt_d = cnt_inc;
            end else begin
              res_valid_o = 1'b1;
              if (pay == '0) begin
                phase_d = PhSize;
                cnt_d   = '0;
              end else begin
                phase_d = PhPayload;
                cnt_d   = pay;
              end
            end
          end
          PhPayload: begin
            cnt_d = cnt_dec;
            if (cnt_dec == '0) begin
              phase_d = PhSize;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      size_len_q <= SizeLenW'(1);
      cnt_q      <= '0;
      acc_q      <= '0;
      type_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      size_len_q <= size_len_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      type_q     <= type_d;
      ovf_q      <= ovf_d;
    end
  end

  `V3CSSD_ASSERT_IMPL(payload_cnt_nonzero_a, clk_i, rst_ni, phase_q == PhPayload, cnt_q != '0, "payload count is zero while skipping")
  `V3CSSD_ASSERT_IMPL(unit_hdr_cnt_a, clk_i, rst_ni, phase_q == PhUnitHdr, cnt_q < AccW'(UnitHdrBytes), "unit header count out of range")
  `V3CSSD_ASSERT_IMPL(size_cnt_a, clk_i, rst_ni, phase_q == PhSize, cnt_q < AccW'(size_len_q), "size field count out of range")
  `V3CSSD_ASSERT_NEXT(after_result_a, clk_i, rst_ni, res_valid_o, phase_q == PhSize || phase_q == PhPayload, "phase after a result is wrong")

endmodule

// ===== sv/v3cssd_out_stage.sv =====
`include "v3c_sample_stream_deframer_core_defines.svh"

module v3cssd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  v3cssd_pkg::out_req_t res_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 stall_i,
  output v3cssd_pkg::out_req_t req_o
);
  import v3cssd_pkg::*;

  logic     valid_q, valid_d;
  out_req_t req_q;

  assign free_o  = ~valid_q | ~stall_i;
  assign valid_o = valid_q;
  assign req_o   = req_q;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = wr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      req_q <= res_i;
    end
  end

  `V3CSSD_ASSERT_IMPL(no_overwrite_a, clk_i, rst_ni, valid_q && stall_i, !wr_i, "result written while held request is stalled")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import v3cssd_pkg::*;

  localparam int unsigned SizeBits = SizeBitsDefault;
  localparam logic [31:0] SizeLimit =
      (SizeBits >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SizeBits) - 64'd1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stream_start;
    logic       typed;
    out_req_t   unit;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_stall_i;
  out_req_t out_req_o;

  out_req_t    pending_units[$];
  int unsigned sent_count;
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;

  phase_e      prs_phase;
  logic [3:0]  prs_size_len;
  logic [31:0] prs_count;
  logic [31:0] prs_size;
  logic [4:0]  prs_type;
  logic        prs_overflow;

  dir_row_t directed_rows[24];

  v3c_sample_stream_deframer_core #(
    .SIZE_BITS(SizeBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #5_000_000;
    $display("v3c_sample_stream_deframer_core: mismatch");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  function automatic unit_class_e class_of_type(logic [4:0] t);
    unit_class_e c;
    if (t == TypeParamSet) c = ClassParamSet;
    else if (t == TypeAtlas) c = ClassAtlas;
    else if (t >= TypeVideoLo && t <= TypeVideoHi) c = ClassVideo;
    else c = ClassUnknown;
    return c;
  endfunction

  function automatic bit parse_byte(input in_req_t r, output out_req_t unit);
    logic [31:0] v;
    logic [31:0] pay;
    logic        err;
    unit = '0;
    if (r.stream_start) begin
      prs_size_len = {1'b0, r.byte_in[7:5]} + 4'd1;
      prs_phase    = PhSize;
      prs_count    = '0;
      prs_size     = '0;
      prs_overflow = 1'b0;
      return 1'b0;
    end
    case (prs_phase)
      PhSize: begin
        if (prs_count == 0) begin
          prs_size     = '0;
          prs_overflow = 1'b0;
        end
        if (prs_overflow || prs_size > (SizeLimit >> 8)) begin
          prs_overflow = 1'b1;
          prs_size     = SizeLimit;
        end else begin
          v = (prs_size << 8) | {24'd0, r.byte_in};
          if (v > SizeLimit) begin
            prs_overflow = 1'b1;
            v = SizeLimit;
          end
          prs_size = v;
        end
        prs_count++;
        if (prs_count >= {28'd0, prs_size_len}) begin
          prs_phase = PhUnitHdr;
          prs_count = '0;
        end
        return 1'b0;
      end
      PhUnitHdr: begin
        if (prs_count == 0) prs_type = r.byte_in[7:3];
        prs_count++;
        if (prs_count < 4) return 1'b0;
        err = (prs_size < 4);
        pay = err ? 32'd0 : prs_size - 32'd4;
        unit.unit_type     = prs_type;
        unit.unit_class    = class_of_type(prs_type);
        unit.unit_size     = prs_size;
        unit.payload_size  = pay;
        unit.size_error    = err;
        unit.size_overflow = prs_overflow;
        prs_phase = (pay == 0) ? PhSize : PhPayload;
        prs_count = pay;
        return 1'b1;
      end
      PhPayload: begin
        if (prs_count > 0) prs_count--;
        if (prs_count == 0) prs_phase = PhSize;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_units.size() == 0) begin
        report_mismatch("unit with none pending, size", 32'd0, out_req_o.unit_size);
      end else begin
        want = pending_units.pop_front();
        if (out_req_o.unit_type !== want.unit_type)
          report_mismatch("unit_type", 32'(want.unit_type), 32'(out_req_o.unit_type));
        if (out_req_o.unit_class !== want.unit_class)
          report_mismatch("unit_class", 32'(want.unit_class), 32'(out_req_o.unit_class));
        if (out_req_o.unit_size !== want.unit_size)
          report_mismatch("unit_size", want.unit_size, out_req_o.unit_size);
        if (out_req_o.payload_size !== want.payload_size)
          report_mismatch("payload_size", want.payload_size, out_req_o.payload_size);
        if (out_req_o.size_error !== want.size_error)
          report_mismatch("size_error", 32'(want.size_error), 32'(out_req_o.size_error));
        if (out_req_o.size_overflow !== want.size_overflow)
          report_mismatch("size_overflow", 32'(want.size_overflow),
                          32'(out_req_o.size_overflow));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st, input logic typed,
                           input out_req_t typed_unit);
    in_req_t  r;
    out_req_t unit;
    bit       has_unit;
    r.byte_in      = b;
    r.stream_start = st;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    has_unit = parse_byte(r, unit);
    if (typed) pending_units.push_back(typed_unit);
    else if (has_unit) pending_units.push_back(unit);
    sent_count++;
  endtask

  task automatic send_stream(input int unsigned target);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned field_len;
    logic [2:0]  len_code;
    logic [31:0] size;
    logic [4:0]  utype;
    bit          big;
    bit          restart;
    stop_at = sent_count + target;
    restart = 1'b1;
    field_len = 1;
    while (sent_count < stop_at) begin
      if (restart || $urandom_range(19) == 0) begin
        len_code = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
        send_byte({len_code, 5'($urandom)}, 1'b1, 1'b0, '0);
        field_len = len_code + 1;
        restart = 1'b0;
      end
      kind = $urandom_range(99);
      if (kind < 5) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), ($urandom_range(5) == 0), 1'b0, '0);
        restart = 1'b1;
      end else begin
        big = (kind >= 88);
        if (kind < 14) size = $urandom_range(3);
        else if (big) size = $urandom;
        else size = $urandom_range(4, 24);
        if (field_len < 4) size = size & ((32'd1 << (8 * field_len)) - 32'd1);
        for (int i = field_len - 1; i >= 0; i--)
          send_byte((i < 4) ? 8'(size >> (8 * i)) : (big ? 8'($urandom) : 8'h00),
                    1'b0, 1'b0, '0);
        utype = ($urandom_range(1) == 0) ? 5'($urandom_range(4)) : 5'($urandom);
        send_byte({utype, 3'($urandom)}, 1'b0, 1'b0, '0);
        repeat (3) send_byte(8'($urandom), 1'b0, 1'b0, '0);
        if (big) begin
          repeat ($urandom_range(0, 6)) send_byte(8'($urandom), 1'b0, 1'b0, '0);
          restart = 1'b1;
        end else if (size >= 4) begin
          for (int unsigned j = 4; j < size; j++)
            send_byte(8'($urandom), 1'b0, 1'b0, '0);
        end
      end
    end
  endtask

  function automatic dir_row_t row(input logic [7:0] b, input logic st);
    dir_row_t d;
    d = '0;
    d.byte_in      = b;
    d.stream_start = st;
    return d;
  endfunction

  function automatic dir_row_t row_unit(input logic [7:0] b, input logic [4:0] t,
                                        input unit_class_e c, input logic [31:0] sz,
                                        input logic [31:0] pay, input logic err,
                                        input logic ovf);
    dir_row_t d;
    d = row(b, 1'b0);
    d.typed              = 1'b1;
    d.unit.unit_type     = t;
    d.unit.unit_class    = c;
    d.unit.unit_size     = sz;
    d.unit.payload_size  = pay;
    d.unit.size_error    = err;
    d.unit.size_overflow = ovf;
    return d;
  endfunction

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    sent_count      = 0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    prs_phase       = PhHeader;
    prs_size_len    = 4'd1;
    prs_count       = '0;
    prs_size        = '0;
    prs_type        = '0;
    prs_overflow    = 1'b0;

    directed_rows = '{
      row(8'h55, 1'b0),
      row(8'h1F, 1'b1),
      row(8'h02, 1'b0),
      row(8'hF8, 1'b0),
      row(8'hFF, 1'b0),
      row(8'hFF, 1'b0),
      row_unit(8'hFF, 5'd31, ClassUnknown, 32'd2, 32'd0, 1'b1, 1'b0),
      row(8'h05, 1'b0),
      row(8'h08, 1'b0),
      row(8'h00, 1'b0),
      row(8'h00, 1'b0),
      row_unit(8'h00, 5'd1, ClassAtlas, 32'd5, 32'd1, 1'b0, 1'b0),
      row(8'hAA, 1'b0),
      row(8'h80, 1'b1),
      row(8'h01, 1'b0),
      row(8'h00, 1'b0),
      row(8'h00, 1'b0),
      row(8'h00, 1'b0),
      row(8'h00, 1'b0),
      row(8'h10, 1'b0),
      row(8'h00, 1'b0),
      row(8'h00, 1'b0),
      row_unit(8'h00, 5'd2, ClassVideo, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0, 1'b1),
      row(8'hFF, 1'b1)
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 12;
    stall_pct       = 78;
    foreach (directed_rows[k])
      send_byte(directed_rows[k].byte_in, directed_rows[k].stream_start,
                directed_rows[k].typed, directed_rows[k].unit);
    send_stream(250);

    sender_idle_pct = 78;
    stall_pct       = 12;
    send_stream(250);

    sender_idle_pct = 0;
    stall_pct       = 0;
    send_stream(250);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("v3c_sample_stream_deframer_core: match");
    end else begin
      $display("v3c_sample_stream_deframer_core: mismatch");
    end
    $finish;
  end

endmodule
